>>> rtl/size_class_slab_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Slab allocator assertion macros
// Shared assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_UNIT_DEFINES_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef SYNTH
// clocked check, off during reset
`define SCA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, live during reset as well
`define SCA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCA_ASSERT(name, prop, msg)
`define SCA_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

>>> rtl/sca_pkg.sv
// ----------------------------------------------------------------------------
// Slab allocator package
// Field widths, size class table, status codes, FSM states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int ADDR_W          = 18;
  localparam int SIZE_W          = 12;
  localparam int PAGE_W          = 6;
  localparam int CLASS_W         = 4;
  localparam int STATUS_W        = 2;
  localparam int LINK_AW         = 15;
  localparam int LINK_DEPTH      = 32768;
  localparam int LINK_SHIFT      = 3;
  localparam int CLASS_MAX       = 10;
  localparam int SLOT_BYTES_W    = 11;
  localparam int CLASS_BYTES_MAX = 1024;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [SLOT_BYTES_W-1:0] slot_bytes_t;

  // slot size of each class, smallest first
  localparam slot_bytes_t CLASS_BYTES [CLASS_MAX] = '{
    11'd8, 11'd16, 11'd24, 11'd32, 11'd48,
    11'd64, 11'd128, 11'd256, 11'd512, 11'd1024
  };

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FIT    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NULL_FREE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CARVE,
    ST_POP
  } sca_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;      // capture request fields
    logic rd_link;      // read link word of current head
    logic wr_free;      // push free address onto class list
    logic carve_start;  // begin carving the fresh page
    logic carve_step;   // write one slot link of the page
    logic pop;          // head takes the link word just read
    logic load_out;     // capture result fields
  } sca_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic fits;
    logic is_free;
    logic addr_null;
    logic head_empty;
    logic carve_last;
  } sca_sts_t;

endpackage

>>> rtl/sca_ifs.sv
// ----------------------------------------------------------------------------
// Slab allocator channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sca_req_if
  import sca_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [SIZE_W-1:0]   request_size;
  logic [ADDR_W-1:0]   free_address;
  logic [PAGE_W-1:0]   fresh_page;

  modport source (output valid, kind, request_size, free_address, fresh_page,
                  input ready);
  modport sink   (input valid, kind, request_size, free_address, fresh_page,
                  output ready);
endinterface

interface sca_rsp_if
  import sca_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   slot_address;
  logic [STATUS_W-1:0] status;
  logic                page_taken;
  logic [CLASS_W-1:0]  size_class;

  modport source (output valid, slot_address, status, page_taken, size_class,
                  input ready);
  modport sink   (input valid, slot_address, status, page_taken, size_class,
                  output ready);
endinterface

>>> rtl/size_class_slab_allocator_unit.sv
// ----------------------------------------------------------------------------
// Size class slab allocator
// Ten size classes with linked free lists over a paged region; refills an
// empty class by carving a fresh page.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+--------------------------------------
//   in_req   | in  | valid/ready        | kind, request_size, free_address,
//            |     |                    | fresh_page
//   out_rsp  | out | valid/ready        | slot_address, status, page_taken,
//            |     |                    | size_class
//
// Alloc from a non-empty list takes EXEC then POP, set by the registered read
// of the single-port link store. Free, null free and no-fit take one request
// per cycle while the result register can load. An alloc on an empty class
// first carves the fresh page, one link write per slot (PAGE_BYTES/size - 1,
// 511 for the 8-byte class on 4 KB pages). Reset empties every class list;
// the link store is not cleared. A new request is taken while the last result
// waits; beyond carves and list reads it stalls only for an unsent result.
// ----------------------------------------------------------------------------
`include "size_class_slab_allocator_unit_defines.svh"

module size_class_slab_allocator_unit
  import sca_pkg::*;
#(
  parameter int NUM_PAGES   = 64,
  parameter int PAGE_BYTES  = 4096,
  parameter int NUM_CLASSES = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  sca_req_if.sink          in_req,
  sca_rsp_if.source        out_rsp
);

  sca_cmd_t cmd;
  sca_sts_t sts;

  // controller
  sca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  sca_datapath #(
    .NUM_PAGES   (NUM_PAGES),
    .PAGE_BYTES  (PAGE_BYTES),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .kind         (in_req.kind),
    .request_size (in_req.request_size),
    .free_address (in_req.free_address),
    .fresh_page   (in_req.fresh_page),
    .cmd          (cmd),
    .sts          (sts),
    .slot_address (out_rsp.slot_address),
    .status       (out_rsp.status),
    .page_taken   (out_rsp.page_taken),
    .size_class   (out_rsp.size_class)
  );

  // at most one link store access per cycle
  `SCA_ASSERT_ALWAYS(a_one_link_op, $onehot0({cmd.rd_link, cmd.wr_free, cmd.carve_step}), "link store over-committed")
  // no request taken while a page is being carved
  `SCA_ASSERT(a_no_take_in_carve, cmd.carve_step |-> !in_req.ready, "request taken during carve")
  // a refilled class always hands out a real slot
  `SCA_ASSERT(a_taken_has_slot, out_rsp.valid && out_rsp.page_taken |-> (out_rsp.status == STAT_DONE && out_rsp.slot_address != '0), "page taken without slot")
  // a failed or ignored request returns no slot
  `SCA_ASSERT(a_fail_no_slot, out_rsp.valid && out_rsp.status != STAT_DONE |-> out_rsp.slot_address == '0 && !out_rsp.page_taken, "slot on failed request")

endmodule

>>> rtl/sca_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module sca_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/sca_ctrl.sv
// ----------------------------------------------------------------------------
// Slab allocator controller
// Sequences request capture, page carving, link access and result load.
// ----------------------------------------------------------------------------
module sca_ctrl
  import sca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  sca_sts_t sts,
  output sca_cmd_t cmd
);

  sca_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register can take a new value
  assign out_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.fits && !sts.is_free) begin
          if (sts.head_empty) begin
            cmd.carve_start = 1'b1;
            state_nxt       = ST_CARVE;
          end else begin
            cmd.rd_link = 1'b1;
            state_nxt   = ST_POP;
          end
        end else if (out_free) begin
          // free, null free or no fitting class: finish now
          cmd.wr_free  = sts.fits && sts.is_free && !sts.addr_null;
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          cmd.load_in  = in_valid;
          state_nxt    = in_valid ? ST_EXEC : ST_IDLE;
        end
      end
      ST_CARVE: begin
        cmd.carve_step = 1'b1;
        if (sts.carve_last) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_POP: begin
        if (out_free) begin
          cmd.pop      = 1'b1;
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          cmd.load_in  = in_valid;
          state_nxt    = in_valid ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result valid: set on load, cleared on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/sca_datapath.sv
// ----------------------------------------------------------------------------
// Slab allocator datapath
// Class pick, list heads, page carving address walk, link store and
// result register.
// ----------------------------------------------------------------------------
module sca_datapath
  import sca_pkg::*;
#(
  parameter int NUM_PAGES   = 64,
  parameter int PAGE_BYTES  = 4096,
  parameter int NUM_CLASSES = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                kind,
  input  logic [SIZE_W-1:0]   request_size,
  input  logic [ADDR_W-1:0]   free_address,
  input  logic [PAGE_W-1:0]   fresh_page,
  input  sca_cmd_t            cmd,
  output sca_sts_t            sts,
  output logic [ADDR_W-1:0]   slot_address,
  output logic [STATUS_W-1:0] status,
  output logic                page_taken,
  output logic [CLASS_W-1:0]  size_class
);

  localparam int CIDX_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int OFF_W     = $clog2(PAGE_BYTES + 2 * CLASS_BYTES_MAX + 1);
  localparam int PTAB_N    = 2 ** PAGE_W;
  localparam int PROD_W    = PAGE_W + $clog2(PAGE_BYTES + 1);

  typedef logic [PAGE_W-1:0] ptab_t [PTAB_N];

  // page number wrapped into the region, one entry per input code
  function automatic ptab_t build_page_tab();
    ptab_t t;
    for (int i = 0; i < PTAB_N; i++) begin
      t[i] = PAGE_W'(i % NUM_PAGES);
    end
    return t;
  endfunction

  localparam ptab_t PAGE_TAB = build_page_tab();

  // request registers
  logic               kind_r;
  logic               fit_r;
  logic [CLASS_W-1:0] cls_r;
  addr_t              faddr_r;
  addr_t              base_r;
  logic               carved_r;
  logic [OFF_W-1:0]   off_r;
  addr_t              heads_r [NUM_CLASSES];

  // result registers
  addr_t               slot_r;
  logic [STATUS_W-1:0] status_r;
  logic                taken_r;
  logic [CLASS_W-1:0]  class_r;

  logic               pick_fit;
  logic [CLASS_W-1:0] pick_cls;
  logic [PROD_W-1:0]  base_prod;
  logic [CIDX_W-1:0]  ci;
  slot_bytes_t        ent;
  addr_t              head_cur;
  addr_t              cur_addr;
  addr_t              next_addr;
  addr_t              first_addr;
  logic [OFF_W-1:0]   off_span;
  logic               carve_last;

  logic               ram_en;
  logic               ram_we;
  logic [LINK_AW-1:0] ram_addr;
  addr_t              ram_wdata;
  addr_t              ram_rdata;

  // smallest class whose slot holds the request
  always_comb begin
    pick_fit = 1'b0;
    pick_cls = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (SIZE_W'(CLASS_BYTES[i]) >= request_size) begin
        pick_fit = 1'b1;
        pick_cls = CLASS_W'(i);
      end
    end
  end

  // page base, kept to the address width
  assign base_prod = PROD_W'(PAGE_TAB[fresh_page]) * PROD_W'(PAGE_BYTES);

  // capture request
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r  <= kind;
      fit_r   <= pick_fit;
      cls_r   <= pick_cls;
      faddr_r <= free_address;
      base_r  <= ADDR_W'(base_prod);
    end
  end

  assign ci       = cls_r[CIDX_W-1:0];
  assign ent      = CLASS_BYTES[cls_r];
  assign head_cur = heads_r[ci];

  // carve walk: the header takes one slot, slots follow at ent steps
  assign cur_addr   = base_r + ADDR_W'(off_r);
  assign next_addr  = cur_addr + ADDR_W'(ent);
  assign first_addr = base_r + ADDR_W'(ent);
  assign off_span   = off_r + (OFF_W'(ent) << 1);
  assign carve_last = off_span > OFF_W'(PAGE_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carved_r <= 1'b0;
    end else if (cmd.load_in) begin
      carved_r <= 1'b0;
    end else if (cmd.carve_start) begin
      carved_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.carve_start) begin
      off_r <= OFF_W'(ent);
    end else if (cmd.carve_step) begin
      off_r <= off_r + OFF_W'(ent);
    end
  end

  // class list heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        heads_r[i] <= '0;
      end
    end else begin
      if (cmd.wr_free) begin
        heads_r[ci] <= faddr_r;
      end
      if (cmd.carve_step && carve_last) begin
        heads_r[ci] <= first_addr;
      end
      if (cmd.pop) begin
        heads_r[ci] <= ram_rdata;
      end
    end
  end

  // link store port
  always_comb begin
    ram_en    = cmd.rd_link || cmd.wr_free || cmd.carve_step;
    ram_we    = cmd.wr_free || cmd.carve_step;
    ram_addr  = head_cur[LINK_SHIFT +: LINK_AW];
    ram_wdata = head_cur;
    if (cmd.wr_free) begin
      ram_addr = faddr_r[LINK_SHIFT +: LINK_AW];
    end else if (cmd.carve_step) begin
      ram_addr  = cur_addr[LINK_SHIFT +: LINK_AW];
      ram_wdata = carve_last ? '0 : next_addr;
    end
  end

  sca_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      slot_r   <= (fit_r && kind_r == KIND_ALLOC) ? head_cur : '0;
      taken_r  <= fit_r && kind_r == KIND_ALLOC && carved_r;
      class_r  <= fit_r ? cls_r : '0;
      if (!fit_r) begin
        status_r <= STAT_NO_FIT;
      end else if (kind_r == KIND_FREE && faddr_r == '0) begin
        status_r <= STAT_NULL_FREE;
      end else begin
        status_r <= STAT_DONE;
      end
    end
  end

  assign sts.fits       = fit_r;
  assign sts.is_free    = (kind_r == KIND_FREE);
  assign sts.addr_null  = (faddr_r == '0);
  assign sts.head_empty = (head_cur == '0);
  assign sts.carve_last = carve_last;

  assign slot_address = slot_r;
  assign status       = status_r;
  assign page_taken   = taken_r;
  assign size_class   = class_r;

endmodule
